// ===== hdl/hrhp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrhp_pkg
// shared types and constants of the request header parser
// ----------------------------------------------------------------------------
package hrhp_pkg;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_URL     = 3'd1,
        PH_VERSION = 3'd2,
        PH_HEADER  = 3'd3,
        PH_BODY    = 3'd4
    } t_phase;

    typedef enum logic [3:0] {
        HM_NAME       = 4'd0,
        HM_CONN_SKIP  = 4'd1,
        HM_CONN_VAL   = 4'd2,
        HM_LEN_SKIP   = 4'd3,
        HM_LEN_DIGITS = 4'd4,
        HM_LEN_STOP   = 4'd5,
        HM_HOST_SKIP  = 4'd6,
        HM_HOST_VAL   = 4'd7,
        HM_IGNORE     = 4'd8
    } t_hmode;

    typedef enum logic [1:0] {
        ST_PENDING  = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_BAD      = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SLASH = 8'h2f;

    typedef struct packed {
        t_status     status;
        logic        keep_alive;
        logic [15:0] body_length;
        logic [10:0] url_start;
        logic [11:0] url_length;
        logic [10:0] host_start;
        logic [11:0] host_length;
        logic [11:0] body_start;
    } t_result;

    function automatic logic [7:0] f_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // keyword characters, lower case; zero past the end
    function automatic logic [7:0] f_kw_get(input logic [4:0] p);
        logic [7:0] r;
        case (p)
            5'd0: r = "g";
            5'd1: r = "e";
            5'd2: r = "t";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] f_kw_ver(input logic [4:0] p);
        logic [7:0] r;
        case (p)
            5'd0: r = "h";
            5'd1: r = "t";
            5'd2: r = "t";
            5'd3: r = "p";
            5'd4: r = "/";
            5'd5: r = "1";
            5'd6: r = ".";
            5'd7: r = "1";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] f_kw_prefix(input logic [4:0] p);
        logic [7:0] r;
        case (p)
            5'd0: r = "h";
            5'd1: r = "t";
            5'd2: r = "t";
            5'd3: r = "p";
            5'd4: r = ":";
            5'd5: r = "/";
            5'd6: r = "/";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] f_kw_conn(input logic [4:0] p);
        logic [7:0] r;
        case (p)
            5'd0: r = "c";
            5'd1: r = "o";
            5'd2: r = "n";
            5'd3: r = "n";
            5'd4: r = "e";
            5'd5: r = "c";
            5'd6: r = "t";
            5'd7: r = "i";
            5'd8: r = "o";
            5'd9: r = "n";
            5'd10: r = ":";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] f_kw_len(input logic [4:0] p);
        logic [7:0] r;
        case (p)
            5'd0: r = "c";
            5'd1: r = "o";
            5'd2: r = "n";
            5'd3: r = "t";
            5'd4: r = "e";
            5'd5: r = "n";
            5'd6: r = "t";
            5'd7: r = "-";
            5'd8: r = "l";
            5'd9: r = "e";
            5'd10: r = "n";
            5'd11: r = "g";
            5'd12: r = "t";
            5'd13: r = "h";
            5'd14: r = ":";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] f_kw_host(input logic [4:0] p);
        logic [7:0] r;
        case (p)
            5'd0: r = "h";
            5'd1: r = "o";
            5'd2: r = "s";
            5'd3: r = "t";
            5'd4: r = ":";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] f_kw_alive(input logic [4:0] p);
        logic [7:0] r;
        case (p)
            5'd0: r = "k";
            5'd1: r = "e";
            5'd2: r = "e";
            5'd3: r = "p";
            5'd4: r = "-";
            5'd5: r = "a";
            5'd6: r = "l";
            5'd7: r = "i";
            5'd8: r = "v";
            5'd9: r = "e";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/hrhp_stream_if.sv =====
// ----------------------------------------------------------------------------
// hrhp_stream_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface hrhp_stream_if #(
    parameter type T_DATA = logic
);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/hrhp_in_t.sv =====
// ----------------------------------------------------------------------------
// hrhp_in_reg
// input register stage: holds one request byte beat for the parse step
// ----------------------------------------------------------------------------
module hrhp_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_restart,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_restart
);
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_restart;

    assign o_ready   = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_byte    = r_byte;
    assign o_restart = r_restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_byte    <= i_byte;
            r_restart <= i_restart;
        end
    end
endmodule

// ===== hdl/hrhp_parse.sv =====
// ----------------------------------------------------------------------------
// hrhp_parse
// per-byte parser state update and result formation
// ----------------------------------------------------------------------------
module hrhp_parse #(
    parameter int BUFFER_BYTES = 2048
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_restart,
    output hrhp_pkg::t_result o_result
);
    localparam int CW = $clog2(BUFFER_BYTES + 1);

    hrhp_pkg::t_phase r_phase, n_phase;
    hrhp_pkg::t_hmode r_hmode, n_hmode;
    logic [CW-1:0] r_count, n_count;
    logic          r_cr, n_cr;
    logic [4:0]    r_lpos, n_lpos;
    logic          r_cmp, n_cmp, r_meth, n_meth, r_pref, n_pref, r_slash, n_slash;
    logic          r_kc, n_kc, r_kl, n_kl, r_kh, n_kh;
    logic          r_ka, n_ka;
    logic [15:0]   r_len, n_len, r_seen, n_seen;
    logic [CW-1:0] r_uoff, n_uoff, r_ucnt, n_ucnt, r_hoff, n_hoff, r_hcnt, n_hcnt;
    logic [CW-1:0] r_boff, n_boff;

    always_comb begin
        logic [7:0]      c, lc;
        logic [CW-1:0]   pos;
        logic            done, bad, blank, lp_k, is_dig;
        logic [19:0]     acc;
        logic [4:0]      lp;
        // start from current state, or cleared state on restart
        n_phase = r_phase; n_hmode = r_hmode; n_count = r_count; n_cr = r_cr;
        n_lpos = r_lpos; n_cmp = r_cmp; n_meth = r_meth; n_pref = r_pref;
        n_slash = r_slash; n_kc = r_kc; n_kl = r_kl; n_kh = r_kh; n_ka = r_ka;
        n_len = r_len; n_seen = r_seen; n_uoff = r_uoff; n_ucnt = r_ucnt;
        n_hoff = r_hoff; n_hcnt = r_hcnt; n_boff = r_boff;
        if (i_restart) begin
            n_phase = hrhp_pkg::PH_METHOD; n_hmode = hrhp_pkg::HM_NAME; n_count = '0;
            n_cr = 1'b0; n_lpos = '0; n_cmp = 1'b1; n_meth = 1'b0; n_pref = 1'b0;
            n_slash = 1'b0; n_kc = 1'b0; n_kl = 1'b0; n_kh = 1'b0; n_ka = 1'b0;
            n_len = '0; n_seen = '0; n_uoff = '0; n_ucnt = '0; n_hoff = '0;
            n_hcnt = '0; n_boff = '0;
        end
        c     = i_byte;
        lc    = hrhp_pkg::f_lower(c);
        blank = (c == hrhp_pkg::CH_SP) || (c == hrhp_pkg::CH_TAB);
        is_dig = (c >= 8'h30) && (c <= 8'h39);
        done  = 1'b0;
        bad   = 1'b0;
        lp    = n_lpos;
        lp_k  = (lp != 5'd31);
        pos   = n_count;
        acc   = '0;
        o_result = '0;
        if (n_count >= CW'(BUFFER_BYTES)) begin
            o_result.status = hrhp_pkg::ST_OVERFLOW;
            bad = 1'b1;
        end else begin
            n_count = n_count + 1'b1;
            if (n_phase == hrhp_pkg::PH_BODY) begin
                n_seen = n_seen + 1'b1;
                if (n_seen >= n_len) done = 1'b1;
            end else if (n_cr) begin
                n_cr = 1'b0;
                if (c != hrhp_pkg::CH_LF) begin
                    bad = 1'b1;
                end else if (n_phase != hrhp_pkg::PH_HEADER) begin
                    if (n_phase == hrhp_pkg::PH_VERSION && n_meth && n_slash && n_cmp
                        && lp == 5'd8) begin
                        n_phase = hrhp_pkg::PH_HEADER;
                        n_hmode = hrhp_pkg::HM_NAME; n_lpos = '0;
                        n_cmp = 1'b0; n_pref = 1'b0;
                        n_kc = 1'b1; n_kl = 1'b1; n_kh = 1'b1;
                    end else begin
                        bad = 1'b1;
                    end
                end else if (n_hmode == hrhp_pkg::HM_NAME && lp == 5'd0) begin
                    n_boff = n_count;
                    if (n_len != 16'd0) begin
                        n_phase = hrhp_pkg::PH_BODY;
                        n_seen = '0;
                    end else begin
                        done = 1'b1;
                    end
                end else begin
                    if (n_hmode == hrhp_pkg::HM_CONN_VAL && n_cmp && lp == 5'd10)
                        n_ka = 1'b1;
                    n_hmode = hrhp_pkg::HM_NAME; n_lpos = '0;
                    n_cmp = 1'b0; n_pref = 1'b0;
                    n_kc = 1'b1; n_kl = 1'b1; n_kh = 1'b1;
                end
            end else if (c == hrhp_pkg::CH_CR) begin
                n_cr = 1'b1;
            end else if (c == hrhp_pkg::CH_LF) begin
                bad = 1'b1;
            end else if (n_phase == hrhp_pkg::PH_HEADER) begin
                case (n_hmode)
                    hrhp_pkg::HM_NAME: begin
                        if (n_kc) begin
                            if (lp >= 5'd11 || lc != hrhp_pkg::f_kw_conn(lp)) n_kc = 1'b0;
                            else if (lp == 5'd10) begin
                                n_hmode = hrhp_pkg::HM_CONN_SKIP; n_kc = 1'b0;
                            end
                        end
                        if (n_kl) begin
                            if (lp >= 5'd15 || lc != hrhp_pkg::f_kw_len(lp)) n_kl = 1'b0;
                            else if (lp == 5'd14) begin
                                n_hmode = hrhp_pkg::HM_LEN_SKIP; n_kl = 1'b0;
                                n_len = '0;
                            end
                        end
                        if (n_kh) begin
                            if (lp >= 5'd5 || lc != hrhp_pkg::f_kw_host(lp)) n_kh = 1'b0;
                            else if (lp == 5'd4) begin
                                n_hmode = hrhp_pkg::HM_HOST_SKIP; n_kh = 1'b0;
                                n_hoff = n_count; n_hcnt = '0;
                            end
                        end
                        if (lp_k) n_lpos = lp + 1'b1;
                        if (n_hmode == hrhp_pkg::HM_NAME && !n_kc && !n_kl && !n_kh)
                            n_hmode = hrhp_pkg::HM_IGNORE;
                    end
                    hrhp_pkg::HM_CONN_SKIP: begin
                        if (!blank) begin
                            n_hmode = hrhp_pkg::HM_CONN_VAL;
                            n_cmp = (lc == hrhp_pkg::f_kw_alive(5'd0));
                            n_lpos = 5'd1;
                        end
                    end
                    hrhp_pkg::HM_CONN_VAL: begin
                        if (lp >= 5'd10 || lc != hrhp_pkg::f_kw_alive(lp)) n_cmp = 1'b0;
                        if (lp_k) n_lpos = lp + 1'b1;
                    end
                    hrhp_pkg::HM_LEN_SKIP, hrhp_pkg::HM_LEN_DIGITS: begin
                        if (n_hmode == hrhp_pkg::HM_LEN_SKIP && blank) begin
                        end else if (is_dig) begin
                            n_hmode = hrhp_pkg::HM_LEN_DIGITS;
                            // x*10 = x*8 + x*2
                            acc = {1'b0, n_len, 3'b000} + {3'b000, n_len, 1'b0}
                                + {12'd0, c - 8'h30};
                            n_len = (acc > 20'd65535) ? 16'hffff : acc[15:0];
                        end else begin
                            n_hmode = hrhp_pkg::HM_LEN_STOP;
                        end
                    end
                    hrhp_pkg::HM_HOST_SKIP: begin
                        if (blank) n_hoff = n_count;
                        else begin
                            n_hmode = hrhp_pkg::HM_HOST_VAL;
                            n_hcnt = CW'(1);
                        end
                    end
                    hrhp_pkg::HM_HOST_VAL: n_hcnt = n_hcnt + 1'b1;
                    default: begin
                    end
                endcase
            end else if (n_phase == hrhp_pkg::PH_METHOD) begin
                if (blank) begin
                    if (n_cmp && lp == 5'd3) n_meth = 1'b1;
                    n_phase = hrhp_pkg::PH_URL; n_lpos = '0; n_pref = 1'b1;
                end else begin
                    if (lp >= 5'd3 || lc != hrhp_pkg::f_kw_get(lp)) n_cmp = 1'b0;
                    if (lp_k) n_lpos = lp + 1'b1;
                end
            end else if (n_phase == hrhp_pkg::PH_URL) begin
                if (blank) begin
                    n_ucnt = n_slash ? pos - n_uoff : '0;
                    n_phase = hrhp_pkg::PH_VERSION; n_lpos = '0; n_cmp = 1'b1;
                end else begin
                    if (lp < 5'd7 && lc != hrhp_pkg::f_kw_prefix(lp)) n_pref = 1'b0;
                    if (!n_slash && c == hrhp_pkg::CH_SLASH &&
                        (lp == 5'd0 || (lp >= 5'd7 && n_pref))) begin
                        n_slash = 1'b1; n_uoff = pos;
                    end
                    if (lp_k) n_lpos = lp + 1'b1;
                end
            end else begin
                if (lp >= 5'd8 || lc != hrhp_pkg::f_kw_ver(lp)) n_cmp = 1'b0;
                if (lp_k) n_lpos = lp + 1'b1;
            end
            if (done) begin
                o_result.status      = hrhp_pkg::ST_COMPLETE;
                o_result.keep_alive  = n_ka;
                o_result.body_length = n_len;
                o_result.url_start   = 11'(n_uoff);
                o_result.url_length  = 12'(n_ucnt);
                o_result.host_start  = 11'(n_hoff);
                o_result.host_length = 12'(n_hcnt);
                o_result.body_start  = 12'(n_boff);
            end else if (bad) begin
                o_result.status = hrhp_pkg::ST_BAD;
            end
        end
        if (done || bad) begin
            n_phase = hrhp_pkg::PH_METHOD; n_hmode = hrhp_pkg::HM_NAME; n_count = '0;
            n_cr = 1'b0; n_lpos = '0; n_cmp = 1'b1; n_meth = 1'b0; n_pref = 1'b0;
            n_slash = 1'b0; n_kc = 1'b0; n_kl = 1'b0; n_kh = 1'b0; n_ka = 1'b0;
            n_len = '0; n_seen = '0; n_uoff = '0; n_ucnt = '0; n_hoff = '0;
            n_hcnt = '0; n_boff = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hrhp_pkg::PH_METHOD; r_hmode <= hrhp_pkg::HM_NAME; r_count <= '0;
            r_cr <= 1'b0; r_lpos <= '0; r_cmp <= 1'b1; r_meth <= 1'b0; r_pref <= 1'b0;
            r_slash <= 1'b0; r_kc <= 1'b0; r_kl <= 1'b0; r_kh <= 1'b0; r_ka <= 1'b0;
            r_len <= '0; r_seen <= '0; r_uoff <= '0; r_ucnt <= '0; r_hoff <= '0;
            r_hcnt <= '0; r_boff <= '0;
        end else if (i_step) begin
            r_phase <= n_phase; r_hmode <= n_hmode; r_count <= n_count;
            r_cr <= n_cr; r_lpos <= n_lpos; r_cmp <= n_cmp; r_meth <= n_meth;
            r_pref <= n_pref; r_slash <= n_slash; r_kc <= n_kc; r_kl <= n_kl;
            r_kh <= n_kh; r_ka <= n_ka; r_len <= n_len; r_seen <= n_seen;
            r_uoff <= n_uoff; r_ucnt <= n_ucnt; r_hoff <= n_hoff;
            r_hcnt <= n_hcnt; r_boff <= n_boff;
        end
    end
endmodule

// ===== hdl/http_request_header_parser_core.sv =====
// an accepted input beat passes through the input register, then the result register, to its result beat
// throughput: one byte per cycle while the result output is not stalled; the parse step updates all state per byte
// a stalled result holds its register while the input register keeps one beat
// reset: synchronous active-low, parser returns to request line with all counts zero
// ----------------------------------------------------------------------------
// http_request_header_parser_core
// byte stream request header parser, one status beat per input byte
// ----------------------------------------------------------------------------
module http_request_header_parser_core #(
    parameter int BUFFER_BYTES = 2048
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hrhp_stream_if.sink   i_req,
    hrhp_stream_if.source o_res
);
    logic       s_valid, s_ready, s_restart;
    logic [7:0] s_byte;
    hrhp_pkg::t_result s_result;
    logic       r_valid;
    hrhp_pkg::t_result r_result;

    hrhp_in_reg u_in (
        .i_clk, .i_rst_n,
        .i_valid(i_req.valid), .o_ready(i_req.ready),
        .i_byte(i_req.data[7:0]), .i_restart(i_req.data[8]),
        .o_valid(s_valid), .i_ready(s_ready), .o_byte(s_byte), .o_restart(s_restart)
    );

    assign s_ready = !r_valid || o_res.ready;

    hrhp_parse #(.BUFFER_BYTES(BUFFER_BYTES)) u_parse (
        .i_clk, .i_rst_n, .i_step(s_valid && s_ready),
        .i_byte(s_byte), .i_restart(s_restart), .o_result(s_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_ready) begin
            r_valid <= s_valid;
        end
        if (s_ready && s_valid) r_result <= s_result;
    end

    assign o_res.valid = r_valid;
    assign o_res.data  = r_result;
endmodule

// ===== hdl/hrhp_checker.sv =====
// ----------------------------------------------------------------------------
// hrhp_checker
// port-level checks of the parser core
// ----------------------------------------------------------------------------
module hrhp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input hrhp_pkg::t_result i_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result beat dropped while stalled");

    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status != hrhp_pkg::ST_COMPLETE |->
        i_out_data.host_length == 12'd0 && i_out_data.body_length == 16'd0)
        else $error("fields set on non-complete status");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input not ready with empty output");

    a_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_valid ##1 !i_in_valid |=> !$rose(i_out_valid))
        else $error("result without input beat");
endmodule

bind http_request_header_parser_core hrhp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_req.valid), .i_in_ready(i_req.ready),
    .i_out_valid(o_res.valid), .i_out_ready(o_res.ready),
    .i_out_data(o_res.data)
);
